@@ hw/rtl/mur_pkg.sv @@
// Shared types and constants for the serial frame receiver.
package mur_pkg;

	localparam logic [7:0] START_BYTE        = 8'hFE;
	localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd250;
	localparam int unsigned FIFO_DEPTH_DEF   = 4;

	// Configuration register indexes
	localparam logic CFG_MAX_PAYLOAD  = 1'b0;
	localparam logic CFG_HANDLER_MASK = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN,
		PH_CMD0,
		PH_CMD1,
		PH_DATA,
		PH_CHECK
	} phase_t;

	typedef enum logic [2:0] {
		ST_GOOD       = 3'd0,
		ST_BAD_START  = 3'd1,
		ST_BAD_CHECK  = 3'd2,
		ST_TOO_LONG   = 3'd3,
		ST_NO_HANDLER = 3'd4
	} status_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [2:0] frame_type;
		logic [4:0] subsystem;
		logic [7:0] command;
		logic [7:0] payload_length;
		status_t    status;
		logic       last;
	} result_t;

endpackage

@@ hw/rtl/mur_core.sv @@
// Frame parser: phase state machine, header capture, check and report forming.
module mur_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             valid_s1,
	input  logic [7:0]       byte_s1,
	output logic             res_valid,
	output mur_pkg::result_t res
);
	import mur_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  max_payload_q;
	logic [31:0] handler_mask_q;
	logic [7:0]  length_q;
	logic [7:0]  cmd0_q;
	logic [7:0]  cmd1_q;
	logic [7:0]  left_q;
	logic [7:0]  chk_q;
	logic [7:0]  left_dec;
	status_t     end_status;

	assign left_dec = left_q - 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q  <= MAX_PAYLOAD_RESET;
			handler_mask_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_PAYLOAD:  max_payload_q  <= cfg_data[7:0];
				CFG_HANDLER_MASK: handler_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT:  phase_d = (byte_s1 == START_BYTE) ? PH_LEN : PH_HUNT;
			PH_LEN:   phase_d = PH_CMD0;
			PH_CMD0:  phase_d = PH_CMD1;
			PH_CMD1:  phase_d = (length_q == 8'd0) ? PH_CHECK : PH_DATA;
			PH_DATA:  phase_d = (left_dec == 8'd0) ? PH_CHECK : PH_DATA;
			PH_CHECK: phase_d = PH_HUNT;
			default:  phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			length_q <= '0;
			cmd0_q   <= '0;
			cmd1_q   <= '0;
			left_q   <= '0;
			chk_q    <= '0;
		end else if (valid_s1) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_LEN: begin
					length_q <= byte_s1;
					chk_q    <= byte_s1;
				end
				PH_CMD0: begin
					cmd0_q <= byte_s1;
					chk_q  <= chk_q ^ byte_s1;
				end
				PH_CMD1: begin
					cmd1_q <= byte_s1;
					chk_q  <= chk_q ^ byte_s1;
					left_q <= length_q;
				end
				PH_DATA: begin
					chk_q  <= chk_q ^ byte_s1;
					left_q <= left_dec;
				end
				default: ;
			endcase
		end
	end

	// Bad check wins over too long, which wins over a missing handler
	always_comb begin
		if (byte_s1 != chk_q)
			end_status = ST_BAD_CHECK;
		else if (length_q > max_payload_q)
			end_status = ST_TOO_LONG;
		else if (!handler_mask_q[cmd0_q[4:0]])
			end_status = ST_NO_HANDLER;
		else
			end_status = ST_GOOD;
	end

	// Result forming
	always_comb begin
		res_valid          = 1'b0;
		res.kind           = 1'b0;
		res.payload_byte   = '0;
		res.payload_index  = '0;
		res.frame_type     = cmd0_q[7:5];
		res.subsystem      = cmd0_q[4:0];
		res.command        = cmd1_q;
		res.payload_length = length_q;
		res.status         = ST_GOOD;
		res.last           = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				res_valid          = valid_s1 && (byte_s1 != START_BYTE);
				res.kind           = 1'b1;
				res.last           = 1'b1;
				res.status         = ST_BAD_START;
				res.frame_type     = '0;
				res.subsystem      = '0;
				res.command        = '0;
				res.payload_length = '0;
			end
			PH_DATA: begin
				res_valid         = valid_s1;
				res.payload_byte  = byte_s1;
				res.payload_index = length_q - left_q;
			end
			PH_CHECK: begin
				res_valid  = valid_s1;
				res.kind   = 1'b1;
				res.last   = 1'b1;
				res.status = end_status;
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/mur_fifo.sv @@
// Small result queue that separates the parser from the output handshake.
module mur_fifo #(
	parameter int unsigned DEPTH = mur_pkg::FIFO_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  mur_pkg::result_t           wr_data,
	input  logic                       pop,
	output mur_pkg::result_t           rd_data,
	output logic                       not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import mur_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	result_t          mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	assign rd_data   = mem[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

@@ hw/rtl/mt_uart_frame_receiver.sv @@
// Top level of the serial command frame receiver.
// Takes one received byte per transaction on the slave stream and hunts for the
// 0xFE start byte, then length, two command bytes, payload and check byte. Each
// payload byte leaves as a result with tuser low; the check byte, or a stray
// byte while hunting, yields an end report with tuser and tlast high and a
// status of good, bad start, bad check, too long or no handler. A byte is
// registered on acceptance and parsed in the following cycle, so each result
// passes the input register and the result queue, and the block sustains one
// byte per cycle while the queue has room; a result queue of DEPTH entries (at
// least three) lets input continue while results wait for the downstream side.
module mt_uart_frame_receiver #(
	parameter int unsigned DEPTH = mur_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] payload_byte, [15:8] payload_index,
	                               // [18:16] frame_type, [23:19] subsystem,
	                               // [31:24] command, [39:32] payload_length,
	                               // [42:40] status, [47:43] zero
	output logic        m_tuser,   // kind
	output logic        m_tlast    // last
);
	import mur_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          res_valid;
	result_t       res;
	result_t       head;
	logic          not_empty;
	logic [CW-1:0] count;
	logic [CW:0]   occupancy;

	// Leave room for the byte in flight and the one about to be taken
	assign occupancy = {1'b0, count} + {{CW{1'b0}}, valid_s1};
	assign s_tready  = (occupancy < (CW + 1)'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= s_tvalid && s_tready;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	mur_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	mur_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.wr_data   (res),
		.pop       (m_tvalid && m_tready),
		.rd_data   (head),
		.not_empty (not_empty),
		.count     (count)
	);

	assign m_tvalid = not_empty;
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {5'b0, head.status, head.payload_length, head.command,
	                   head.subsystem, head.frame_type, head.payload_index,
	                   head.payload_byte};

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (count < CW'(DEPTH)) || (m_tvalid && m_tready))
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= (CW + 1)'(DEPTH))
		else $error("queue occupancy beyond depth");

	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser))
		else $error("tlast and kind disagree");

	a_payload_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[42:40] == ST_GOOD))
		else $error("payload result with nonzero status");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the serial command frame receiver.
`timescale 1ns / 100ps

module tb_top;
	import mur_pkg::*;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;          // [7:0] payload_byte, [15:8] payload_index,
	                               // [18:16] frame_type, [23:19] subsystem,
	                               // [31:24] command, [39:32] payload_length,
	                               // [42:40] status, [47:43] zero
	logic        m_tuser;          // kind
	logic        m_tlast;          // last

	mt_uart_frame_receiver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Deframer state and register copies
	phase_t      rx_phase    = PH_HUNT;
	logic [7:0]  hdr_len     = '0;
	logic [7:0]  hdr_cmd0    = '0;
	logic [7:0]  hdr_cmd1    = '0;
	logic [7:0]  data_left   = '0;
	logic [7:0]  fcs_acc     = '0;
	logic [7:0]  lim_payload = MAX_PAYLOAD_RESET;
	logic [31:0] sub_mask    = '0;

	logic [7:0]  rx_pending[$];
	result_t     frame_results[$];
	int unsigned bytes_queued = 0;
	int unsigned err_cnt      = 0;
	int unsigned idle_pct     = 14;
	logic        stall_req    = 1'b0;
	logic        stall_used;
	int unsigned stall_left;

	function automatic void deframe_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		r.frame_type     = hdr_cmd0[7:5];
		r.subsystem      = hdr_cmd0[4:0];
		r.command        = hdr_cmd1;
		r.payload_length = hdr_len;
		case (rx_phase)
			PH_LEN: begin
				hdr_len  = b;
				fcs_acc  = b;
				rx_phase = PH_CMD0;
			end
			PH_CMD0: begin
				hdr_cmd0 = b;
				fcs_acc ^= b;
				rx_phase = PH_CMD1;
			end
			PH_CMD1: begin
				hdr_cmd1  = b;
				fcs_acc  ^= b;
				data_left = hdr_len;
				rx_phase  = (hdr_len == 8'd0) ? PH_CHECK : PH_DATA;
			end
			PH_DATA: begin
				fcs_acc ^= b;
				r.payload_byte  = b;
				r.payload_index = hdr_len - data_left;
				r.status        = ST_GOOD;
				frame_results.push_back(r);
				data_left = data_left - 8'd1;
				if (data_left == 8'd0)
					rx_phase = PH_CHECK;
			end
			PH_CHECK: begin
				r.kind = 1'b1;
				r.last = 1'b1;
				// bad check outranks too long, which outranks no handler
				if (b != fcs_acc)
					r.status = ST_BAD_CHECK;
				else if (hdr_len > lim_payload)
					r.status = ST_TOO_LONG;
				else if (!sub_mask[hdr_cmd0[4:0]])
					r.status = ST_NO_HANDLER;
				else
					r.status = ST_GOOD;
				frame_results.push_back(r);
				rx_phase = PH_HUNT;
			end
			default: begin
				rx_phase = PH_HUNT;
				if (b == START_BYTE) begin
					rx_phase = PH_LEN;
				end else begin
					r        = '0;
					r.kind   = 1'b1;
					r.last   = 1'b1;
					r.status = ST_BAD_START;
					frame_results.push_back(r);
				end
			end
		endcase
	endfunction

	// Driver: hold each byte until accepted, then maybe offer the next
	always @(posedge clk or negedge arst_n) begin : byte_driver
		logic offering;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			offering = s_tvalid;
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata);
				offering = 1'b0;
			end
			if (!offering && rx_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				s_tdata <= rx_pending.pop_front();
				offering = 1'b1;
			end
			s_tvalid <= offering;
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endtask

	// Monitor: compare each result transaction and pace tready
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_t want;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
			stall_used <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (frame_results.size() == 0) begin
					$error("unexpected result: tdata %0h tuser %0b tlast %0b",
					       m_tdata, m_tuser, m_tlast);
					err_cnt++;
				end else begin
					want = frame_results.pop_front();
					check_field("kind", 32'(want.kind), 32'(m_tuser));
					check_field("payload_byte", 32'(want.payload_byte),
					            32'(m_tdata[7:0]));
					check_field("payload_index", 32'(want.payload_index),
					            32'(m_tdata[15:8]));
					check_field("frame_type", 32'(want.frame_type),
					            32'(m_tdata[18:16]));
					check_field("subsystem", 32'(want.subsystem),
					            32'(m_tdata[23:19]));
					check_field("command", 32'(want.command),
					            32'(m_tdata[31:24]));
					check_field("payload_length", 32'(want.payload_length),
					            32'(m_tdata[39:32]));
					check_field("status", 32'(want.status),
					            32'(m_tdata[42:40]));
					check_field("last", 32'(want.last), 32'(m_tlast));
				end
			end
			if (stall_req && !stall_used) begin
				stall_left <= 300;
				stall_used <= 1'b1;
				m_tready   <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_PAYLOAD)
			lim_payload = val[7:0];
		else
			sub_mask = val;
	endtask

	task automatic queue_frame(input logic [7:0] len, input logic [7:0] c0,
	                           input logic [7:0] c1, input bit bad_fcs, input bit edge_fill);
		logic [7:0] acc;
		logic [7:0] pb;
		rx_pending.push_back(START_BYTE);
		rx_pending.push_back(len);
		rx_pending.push_back(c0);
		rx_pending.push_back(c1);
		acc = len ^ c0 ^ c1;
		for (int i = 0; i < len; i++) begin
			pb = edge_fill ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
			acc ^= pb;
			rx_pending.push_back(pb);
		end
		// flip one bit to break the check byte
		if (bad_fcs)
			acc ^= 8'h01 << $urandom_range(0, 7);
		rx_pending.push_back(acc);
		bytes_queued += len + 5;
	endtask

	task automatic queue_random(input int unsigned budget);
		int unsigned stop_at;
		int unsigned pick;
		stop_at = bytes_queued + budget;
		while (bytes_queued < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				rx_pending.push_back(8'($urandom));
				bytes_queued++;
			end else begin
				queue_frame(8'($urandom_range(0, 12)), 8'($urandom), 8'($urandom),
				            pick < 20, 1'b0);
			end
		end
	endtask

	// Wait for the byte queue and all expected results to drain
	task automatic wait_idle();
		while (rx_pending.size() != 0 || s_tvalid || frame_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: stray bytes, no handler, bad check
		rx_pending.push_back(8'h00);
		rx_pending.push_back(8'hFF);
		bytes_queued += 2;
		queue_frame(8'd0, 8'hE5, 8'h00, 1'b0, 1'b0);
		queue_frame(8'd1, 8'h00, 8'hFF, 1'b1, 1'b1);
		wait_idle();

		// Zero max length with every handler present: good and too long
		write_reg(CFG_MAX_PAYLOAD, 32'd0);
		write_reg(CFG_HANDLER_MASK, 32'hFFFF_FFFF);
		queue_frame(8'd0, 8'hFF, 8'h00, 1'b0, 1'b0);
		queue_frame(8'd2, 8'h1F, 8'hFF, 1'b0, 1'b1);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_MAX_PAYLOAD, 32'd255);
					write_reg(CFG_HANDLER_MASK, 32'hFFFF_FFFF);
				end
				1: begin
					write_reg(CFG_MAX_PAYLOAD, 32'd6);
					write_reg(CFG_HANDLER_MASK, $urandom);
					stall_req <= 1'b1;
				end
				2: begin
					write_reg(CFG_MAX_PAYLOAD, 32'd0);
					write_reg(CFG_HANDLER_MASK, 32'd0);
					idle_pct <= 0;
				end
				3: begin
					write_reg(CFG_MAX_PAYLOAD, $urandom_range(0, 255));
					write_reg(CFG_HANDLER_MASK, $urandom);
					idle_pct <= 14;
				end
				4: begin
					write_reg(CFG_MAX_PAYLOAD, 32'(MAX_PAYLOAD_RESET));
					write_reg(CFG_HANDLER_MASK, $urandom);
				end
				default: begin
					write_reg(CFG_MAX_PAYLOAD, $urandom_range(1, 20));
					write_reg(CFG_HANDLER_MASK, $urandom);
				end
			endcase
			queue_random(55);
			// one frame of the longest length
			if (ph == 3)
				queue_frame(8'd255, 8'($urandom), 8'($urandom), 1'b0, 1'b0);
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (frame_results.size() != 0) begin
			$error("%0d expected results never arrived", frame_results.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
